@@ sv/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, codes and the control store of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Port field widths
  localparam int REQ_W    = 2;
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int ROW_IN_W = 5;
  localparam int COL_IN_W = 7;
  localparam int POS_W    = 11;
  localparam int CELL_W   = CHAR_W + ATTR_W;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;
  localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, CH_SPACE};

  // Micro-instruction fields
  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_ADVANCE,
    CUR_NEWLINE,
    CUR_BACK,
    CUR_HOME,
    CUR_LAST_ROW
  } cur_op_e;

  typedef enum logic [1:0] {
    WRC_NONE,
    WRC_CHAR,
    WRC_BLANK
  } wr_cur_e;

  typedef enum logic [1:0] {
    SW_NONE,
    SW_INIT,
    SW_CLEAR,
    SW_SCROLL
  } sweep_e;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_ALWAYS,
    JMP_COL_ZERO,
    JMP_NO_OVF,
    JMP_SWEEP_MORE
  } jump_e;

  typedef enum logic [1:0] {
    END_NONE,
    END_RESULT,
    END_QUIET
  } end_e;

  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  typedef struct packed {
    cur_op_e cur_op;
    wr_cur_e wr_cur;
    sweep_e  sweep;
    logic    ptr_clr;
    logic    rd_cell;
    jump_e   jump;
    upc_t    target;
    end_e    fin;
  } uinstr_t;

  // Status fed back to the sequencer for conditional jumps
  typedef struct packed {
    logic col_zero;
    logic row_ovf;
    logic sweep_last;
  } ucond_t;

  // Program addresses
  localparam upc_t U_INIT0 = 4'd0;
  localparam upc_t U_INIT1 = 4'd1;
  localparam upc_t U_QUIET = 4'd2;
  localparam upc_t U_PUT   = 4'd3;
  localparam upc_t U_NL    = 4'd4;
  localparam upc_t U_BS0   = 4'd5;
  localparam upc_t U_BS1   = 4'd6;
  localparam upc_t U_BS2   = 4'd7;
  localparam upc_t U_CHK   = 4'd8;
  localparam upc_t U_SC0   = 4'd9;
  localparam upc_t U_SC1   = 4'd10;
  localparam upc_t U_FIN   = 4'd11;
  localparam upc_t U_CL0   = 4'd12;
  localparam upc_t U_CL1   = 4'd13;
  localparam upc_t U_CL2   = 4'd14;
  localparam upc_t U_RD0   = 4'd15;

  localparam uinstr_t UI_NOP = '{
    cur_op:  CUR_HOLD,
    wr_cur:  WRC_NONE,
    sweep:   SW_NONE,
    ptr_clr: 1'b0,
    rd_cell: 1'b0,
    jump:    JMP_NEXT,
    target:  U_INIT0,
    fin:     END_NONE
  };

  // Control store
  function automatic uinstr_t ucode(upc_t upc);
    uinstr_t ui;
    ui = UI_NOP;
    unique case (upc)
      U_INIT0: begin
        ui.ptr_clr = 1'b1;
      end
      U_INIT1: begin
        ui.sweep  = SW_INIT;
        ui.jump   = JMP_SWEEP_MORE;
        ui.target = U_INIT1;
      end
      U_QUIET: begin
        ui.fin = END_QUIET;
      end
      U_PUT: begin
        ui.wr_cur = WRC_CHAR;
        ui.cur_op = CUR_ADVANCE;
        ui.jump   = JMP_ALWAYS;
        ui.target = U_CHK;
      end
      U_NL: begin
        ui.cur_op = CUR_NEWLINE;
        ui.jump   = JMP_ALWAYS;
        ui.target = U_CHK;
      end
      U_BS0: begin
        ui.jump   = JMP_COL_ZERO;
        ui.target = U_FIN;
      end
      U_BS1: begin
        ui.cur_op = CUR_BACK;
      end
      U_BS2: begin
        ui.wr_cur = WRC_BLANK;
        ui.jump   = JMP_ALWAYS;
        ui.target = U_FIN;
      end
      U_CHK: begin
        ui.jump   = JMP_NO_OVF;
        ui.target = U_FIN;
      end
      U_SC0: begin
        ui.ptr_clr = 1'b1;
        ui.cur_op  = CUR_LAST_ROW;
      end
      U_SC1: begin
        ui.sweep  = SW_SCROLL;
        ui.jump   = JMP_SWEEP_MORE;
        ui.target = U_SC1;
      end
      U_FIN: begin
        ui.fin = END_RESULT;
      end
      U_CL0: begin
        ui.ptr_clr = 1'b1;
        ui.cur_op  = CUR_HOME;
      end
      U_CL1: begin
        ui.sweep  = SW_CLEAR;
        ui.jump   = JMP_SWEEP_MORE;
        ui.target = U_CL1;
      end
      U_CL2: begin
        ui.jump   = JMP_ALWAYS;
        ui.target = U_FIN;
      end
      U_RD0: begin
        ui.rd_cell = 1'b1;
        ui.jump    = JMP_ALWAYS;
        ui.target  = U_FIN;
      end
      default: begin
        ui = UI_NOP;
      end
    endcase
    return ui;
  endfunction

  // Dispatch: program entry for an accepted request
  function automatic upc_t entry_of(logic [REQ_W-1:0] req, logic [CHAR_W-1:0] ch);
    upc_t e;
    unique case (req)
      REQ_PUT: begin
        if (ch == CH_NEWLINE) begin
          e = U_NL;
        end else if (ch == CH_BACKSPACE) begin
          e = U_BS0;
        end else begin
          e = U_PUT;
        end
      end
      REQ_CLEAR: e = U_CL0;
      REQ_READ:  e = U_RD0;
      default:   e = U_FIN;
    endcase
    return e;
  endfunction

endpackage

@@ sv/tcw_useq.sv @@
// ----------------------------------------------------------------------------
// tcw_useq
// Micro-sequencer: step counter over the control store, conditional jumps,
// dispatch on a new request and the busy flag.
// ----------------------------------------------------------------------------
module tcw_useq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  tcw_pkg::upc_t     entry_i,
  input  tcw_pkg::ucond_t   cond_i,
  input  logic              stall_i,
  output tcw_pkg::uinstr_t  ctrl_o,
  output logic              busy_o
);

  tcw_pkg::upc_t    upc_q, upc_d;
  logic             busy_q, busy_d;
  tcw_pkg::uinstr_t ui;
  logic             taken;

  assign ui = tcw_pkg::ucode(upc_q);

  always_comb begin
    unique case (ui.jump)
      tcw_pkg::JMP_ALWAYS:     taken = 1'b1;
      tcw_pkg::JMP_COL_ZERO:   taken = cond_i.col_zero;
      tcw_pkg::JMP_NO_OVF:     taken = !cond_i.row_ovf;
      tcw_pkg::JMP_SWEEP_MORE: taken = !cond_i.sweep_last;
      default:                 taken = 1'b0;
    endcase
  end

  always_comb begin
    upc_d  = upc_q;
    busy_d = busy_q;
    if (!busy_q) begin
      if (start_i) begin
        upc_d  = entry_i;
        busy_d = 1'b1;
      end
    end else begin
      unique case (ui.fin)
        tcw_pkg::END_RESULT: begin
          // holds here until the output register is free
          if (!stall_i) begin
            busy_d = 1'b0;
          end
        end
        tcw_pkg::END_QUIET: begin
          busy_d = 1'b0;
        end
        default: begin
          upc_d = taken ? ui.target : upc_q + 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q  <= tcw_pkg::U_INIT0;
      busy_q <= 1'b1;
    end else begin
      upc_q  <= upc_d;
      busy_q <= busy_d;
    end
  end

  assign ctrl_o = busy_q ? ui : tcw_pkg::UI_NOP;
  assign busy_o = busy_q;

endmodule

@@ sv/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine over a ROWS x COLUMNS grid of character cells.
// ----------------------------------------------------------------------------
// One request is in flight at a time; in_ready_o is high whenever the
// sequencer is idle, even while a result waits in the output register.
// The grid lives in a single-port-write, single-port-read RAM, so clear and
// scroll visit one cell per cycle (scroll reads the cell one row below and
// writes it back in the next cycle). After reset the block runs a clearing
// pass that fills every cell with a space in attribute 0x0F; no request is
// taken until it ends, though the attribute register can be written
// throughout.
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tcw_pkg::ATTR_W-1:0]    cfg_data_i,
  // requests
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tcw_pkg::REQ_W-1:0]     req_type_i,
  input  logic [tcw_pkg::CHAR_W-1:0]    char_code_i,
  input  logic [tcw_pkg::ROW_IN_W-1:0]  cell_row_i,
  input  logic [tcw_pkg::COL_IN_W-1:0]  cell_col_i,
  // results
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tcw_pkg::POS_W-1:0]     cursor_pos_o,
  output logic [tcw_pkg::CHAR_W-1:0]    cell_char_o,
  output logic [tcw_pkg::ATTR_W-1:0]    cell_attr_o
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int KEEP  = CELLS - COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS + 1);
  localparam int LIN_W = $clog2((ROWS + 1) * COLUMNS);
  localparam int RDL_W = $clog2(32 * COLUMNS + 128);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  tcw_pkg::uinstr_t ctrl;
  tcw_pkg::ucond_t  cond;
  logic             busy;
  logic             start;
  logic             stall;
  logic             load_out;

  assign in_ready_o = !busy;
  assign start      = in_valid_i && in_ready_o;
  assign stall      = out_valid_o && !out_ready_i;
  assign load_out   = (ctrl.fin == tcw_pkg::END_RESULT) && !stall;

  tcw_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .entry_i (tcw_pkg::entry_of(req_type_i, char_code_i)),
    .cond_i  (cond),
    .stall_i (stall),
    .ctrl_o  (ctrl),
    .busy_o  (busy)
  );

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  logic [tcw_pkg::ATTR_W-1:0]   attr_q;
  logic [tcw_pkg::CHAR_W-1:0]   char_q;
  logic [tcw_pkg::ROW_IN_W-1:0] rrow_q;
  logic [tcw_pkg::COL_IN_W-1:0] rcol_q;

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic          rd_hit_q, rd_hit_d;

  logic                       wb_valid_q;
  logic [AW-1:0]              wb_addr_q;
  tcw_pkg::sweep_e            wb_kind_q;
  logic                       wb_copy_q;

  logic [LIN_W-1:0]           cur_lin;
  logic [RDL_W-1:0]           rd_lin;
  logic                       rd_in_grid;
  logic [tcw_pkg::CELL_W-1:0] blank;

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [tcw_pkg::CELL_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic [tcw_pkg::CELL_W-1:0] mem_q [CELLS];
  logic [tcw_pkg::CELL_W-1:0] rdata_q;

  logic                       out_valid_q;
  logic [tcw_pkg::POS_W-1:0]  pos_q;
  logic [tcw_pkg::CHAR_W-1:0] cchar_q;
  logic [tcw_pkg::ATTR_W-1:0] cattr_q;

  assign blank   = {attr_q, tcw_pkg::CH_SPACE};
  assign cur_lin = LIN_W'(row_q) * LIN_W'(COLUMNS) + LIN_W'(col_q);
  assign rd_lin  = RDL_W'(rrow_q) * RDL_W'(COLUMNS) + RDL_W'(rcol_q);
  assign rd_in_grid = (int'(rrow_q) < ROWS) && (int'(rcol_q) < COLUMNS);

  assign cond.col_zero   = (col_q == '0);
  assign cond.row_ovf    = (row_q == RW'(ROWS));
  assign cond.sweep_last = (ptr_q == AW'(CELLS - 1));

  // Cursor
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    unique case (ctrl.cur_op)
      tcw_pkg::CUR_ADVANCE: begin
        if (col_q == CW'(COLUMNS - 1)) begin
          col_d = '0;
          row_d = row_q + 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      tcw_pkg::CUR_NEWLINE: begin
        col_d = '0;
        row_d = row_q + 1'b1;
      end
      tcw_pkg::CUR_BACK:     col_d = col_q - 1'b1;
      tcw_pkg::CUR_HOME: begin
        col_d = '0;
        row_d = '0;
      end
      tcw_pkg::CUR_LAST_ROW: row_d = RW'(ROWS - 1);
      default: begin
        col_d = col_q;
        row_d = row_q;
      end
    endcase
  end

  always_comb begin
    ptr_d = ptr_q;
    if (ctrl.ptr_clr) begin
      ptr_d = '0;
    end else if (ctrl.sweep != tcw_pkg::SW_NONE) begin
      ptr_d = ptr_q + 1'b1;
    end
  end

  always_comb begin
    rd_hit_d = rd_hit_q;
    if (start) begin
      rd_hit_d = 1'b0;
    end else if (ctrl.rd_cell) begin
      rd_hit_d = rd_in_grid;
    end
  end

  // RAM ports: the sweep's write-behind beat has the write port first
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_lin[AW-1:0];
    mem_wdata = blank;
    if (wb_valid_q) begin
      mem_we    = 1'b1;
      mem_waddr = wb_addr_q;
      case (wb_kind_q)
        tcw_pkg::SW_INIT:   mem_wdata = tcw_pkg::RESET_CELL;
        tcw_pkg::SW_SCROLL: mem_wdata = wb_copy_q ? rdata_q : blank;
        default:            mem_wdata = blank;
      endcase
    end else if (ctrl.wr_cur == tcw_pkg::WRC_CHAR) begin
      mem_we    = 1'b1;
      mem_wdata = {attr_q, char_q};
    end else if (ctrl.wr_cur == tcw_pkg::WRC_BLANK) begin
      mem_we    = 1'b1;
    end
  end

  always_comb begin
    if (ctrl.rd_cell) begin
      mem_re    = rd_in_grid;
      mem_raddr = rd_lin[AW-1:0];
    end else begin
      // scroll: fetch the cell one row down
      mem_re    = (ctrl.sweep == tcw_pkg::SW_SCROLL) && (ptr_q < AW'(KEEP));
      mem_raddr = ptr_q + AW'(COLUMNS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q      <= tcw_pkg::RESET_ATTR;
      col_q       <= '0;
      row_q       <= '0;
      ptr_q       <= '0;
      rd_hit_q    <= 1'b0;
      wb_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        attr_q <= cfg_data_i;
      end
      col_q      <= col_d;
      row_q      <= row_d;
      ptr_q      <= ptr_d;
      rd_hit_q   <= rd_hit_d;
      wb_valid_q <= (ctrl.sweep != tcw_pkg::SW_NONE);
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (start) begin
      char_q <= char_code_i;
      rrow_q <= cell_row_i;
      rcol_q <= cell_col_i;
    end
    wb_addr_q <= ptr_q;
    wb_kind_q <= ctrl.sweep;
    wb_copy_q <= (ptr_q < AW'(KEEP));
    if (load_out) begin
      pos_q   <= tcw_pkg::POS_W'(cur_lin);
      cchar_q <= rd_hit_q ? rdata_q[tcw_pkg::CHAR_W-1:0] : '0;
      cattr_q <= rd_hit_q ? rdata_q[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W] : '0;
    end
  end

  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign cursor_pos_o = pos_q;
  assign cell_char_o  = cchar_q;
  assign cell_attr_o  = cattr_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // a sweep's trailing write beat always lands before the sequencer goes idle
  a_wb_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_valid_q |-> busy)
    else $error("write-behind beat outside a busy sequence");

  // between requests the cursor is inside the grid
  a_cursor_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> (int'(row_q) < ROWS) && (int'(col_q) < COLUMNS))
    else $error("cursor outside grid while idle");

  // no cursor write while the row has run past the grid
  a_cur_write_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.wr_cur != tcw_pkg::WRC_NONE) |-> (int'(row_q) < ROWS))
    else $error("cell write with cursor row out of range");

  // a result is only loaded into a free or draining output register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_o || out_ready_i))
    else $error("result overwrote a pending beat");

endmodule

@@ dv/tb_text_console_writer.sv @@
// ----------------------------------------------------------------------------
// tb_text_console_writer
// Self-checking bench for the text console writer. Requests are driven
// through the valid/ready input channel. A cycle-free model of the 80x25 grid,
// the cursor and the attribute register predicts every result beat. Directed
// corner cases come first. Random text lines follow, which wrap, scroll,
// backspace, clear and read back cells under several attribute settings and
// with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_text_console_writer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REQ_W    = tcw_pkg::REQ_W;
  localparam int CHAR_W   = tcw_pkg::CHAR_W;
  localparam int ATTR_W   = tcw_pkg::ATTR_W;
  localparam int ROW_IN_W = tcw_pkg::ROW_IN_W;
  localparam int COL_IN_W = tcw_pkg::COL_IN_W;
  localparam int POS_W    = tcw_pkg::POS_W;
  localparam int CELL_W   = tcw_pkg::CELL_W;

  localparam int COLUMNS       = 80;
  localparam int ROWS          = 25;
  localparam int ROW_MAX       = (1 << ROW_IN_W) - 1;
  localparam int COL_MAX       = (1 << COL_IN_W) - 1;
  localparam int PRESSURE_HOLD = 400;
  // a sweep, a long receiver hold and the clearing pass, with a wide margin
  localparam int STALL_LIMIT   = 20000;

  // the one request code the block ignores
  localparam logic [REQ_W-1:0] REQ_IGNORED = 2'd3;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [CHAR_W-1:0] ch;
    logic [ATTR_W-1:0] attr;
  } console_result_t;

  class console_checker;
    logic [CELL_W-1:0] grid [ROWS*COLUMNS];
    int unsigned       cur_col;
    int unsigned       cur_row;
    logic [ATTR_W-1:0] attr;
    console_result_t   expected_results[$];
    int errors, checked, scrolls, wraps, clears, reads_in, reads_out;

    function new();
      foreach (grid[i]) grid[i] = tcw_pkg::RESET_CELL;
      cur_col = 0;
      cur_row = 0;
      attr    = tcw_pkg::RESET_ATTR;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void set_attribute(logic [ATTR_W-1:0] value);
      attr = value;
    endfunction

    function void scroll_grid();
      for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) grid[i] = grid[i + COLUMNS];
      for (int i = (ROWS - 1) * COLUMNS; i < ROWS * COLUMNS; i++)
        grid[i] = {attr, tcw_pkg::CH_SPACE};
      scrolls++;
    endfunction

    function void put_char(logic [CHAR_W-1:0] c);
      if (c == tcw_pkg::CH_NEWLINE) begin
        cur_col = 0;
        cur_row++;
      end else if (c == tcw_pkg::CH_BACKSPACE) begin
        if (cur_col == 0) return;
        cur_col--;
        grid[cur_row * COLUMNS + cur_col] = {attr, tcw_pkg::CH_SPACE};
      end else begin
        grid[cur_row * COLUMNS + cur_col] = {attr, c};
        cur_col++;
        if (cur_col >= COLUMNS) wraps++;
      end
      if (cur_col >= COLUMNS) begin
        cur_col = 0;
        cur_row++;
      end
      if (cur_row >= ROWS) begin
        scroll_grid();
        cur_row = ROWS - 1;
      end
    endfunction

    // Apply one accepted request and queue the result beat it must produce
    function void note_request(logic [REQ_W-1:0] req, logic [CHAR_W-1:0] ch,
                               logic [ROW_IN_W-1:0] row, logic [COL_IN_W-1:0] col);
      console_result_t want;
      want = '0;
      case (req)
        tcw_pkg::REQ_PUT: begin
          put_char(ch);
        end
        tcw_pkg::REQ_CLEAR: begin
          foreach (grid[i]) grid[i] = {attr, tcw_pkg::CH_SPACE};
          cur_col = 0;
          cur_row = 0;
          clears++;
        end
        tcw_pkg::REQ_READ: begin
          if (row < ROWS && col < COLUMNS) begin
            {want.attr, want.ch} = grid[row * COLUMNS + col];
            reads_in++;
          end else begin
            reads_out++;
          end
        end
        default: begin
        end
      endcase
      want.pos = POS_W'(cur_row * COLUMNS + cur_col);
      expected_results.push_back(want);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic [POS_W-1:0] pos, logic [CHAR_W-1:0] ch, logic [ATTR_W-1:0] at);
      console_result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing outstanding: pos=%0d", pos));
        return;
      end
      want = expected_results.pop_front();
      checked++;
      if (pos !== want.pos)
        report_mismatch($sformatf("cursor_pos got %0d want %0d", pos, want.pos));
      if (ch !== want.ch)
        report_mismatch($sformatf("cell_char got %02h want %02h", ch, want.ch));
      if (at !== want.attr)
        report_mismatch($sformatf("cell_attr got %02h want %02h", at, want.attr));
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [ATTR_W-1:0]   cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [REQ_W-1:0]    req_type_i;
  logic [CHAR_W-1:0]   char_code_i;
  logic [ROW_IN_W-1:0] cell_row_i;
  logic [COL_IN_W-1:0] cell_col_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [POS_W-1:0]    cursor_pos_o;
  logic [CHAR_W-1:0]   cell_char_o;
  logic [ATTR_W-1:0]   cell_attr_o;

  console_checker board;
  bit sender_idle;
  bit receiver_idle;
  int receiver_hold_request;
  int n_items;
  int n_ignored;
  int n_settings;
  int quiet_cycles;

  text_console_writer #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .char_code_i (char_code_i),
    .cell_row_i  (cell_row_i),
    .cell_col_i  (cell_col_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cursor_pos_o(cursor_pos_o),
    .cell_char_o (cell_char_o),
    .cell_attr_o (cell_attr_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // mostly back-to-back, some short gaps, the odd long one
  function automatic int pick_gap(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Called just after a falling edge; returns just after one.
  // Valid is left high so a following beat can go out without a gap.
  task automatic send_request(logic [REQ_W-1:0] req, logic [CHAR_W-1:0] ch,
                              logic [ROW_IN_W-1:0] row, logic [COL_IN_W-1:0] col);
    int gap;
    gap = pick_gap(sender_idle);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    char_code_i <= ch;
    cell_row_i  <= row;
    cell_col_i  <= col;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_request(req, ch, row, col);
    if (req == REQ_IGNORED) n_ignored++;
    else n_items++;
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every result beat is back
  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_attribute(logic [ATTR_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.set_attribute(value);
    n_settings++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_read();
    int r;
    logic [ROW_IN_W-1:0] row;
    logic [COL_IN_W-1:0] col;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      row = ROW_IN_W'(board.cur_row);
      col = COL_IN_W'($urandom_range(0, COLUMNS - 1));
    end else if (r < 85) begin
      row = ROW_IN_W'($urandom_range(0, ROWS - 1));
      col = COL_IN_W'($urandom_range(0, COLUMNS - 1));
    end else if (r < 93) begin
      row = ROW_IN_W'($urandom_range(ROWS, ROW_MAX));
      col = COL_IN_W'($urandom_range(0, COL_MAX));
    end else begin
      row = ROW_IN_W'($urandom_range(0, ROW_MAX));
      col = COL_IN_W'($urandom_range(COLUMNS, COL_MAX));
    end
    send_request(tcw_pkg::REQ_READ, CHAR_W'($urandom), row, col);
  endtask

  // One line of text: mostly short or empty so the cursor reaches the
  // bottom row and scrolls, now and then long enough to wrap
  task automatic type_line();
    int len;
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) len = 0;
    else if (r < 85) len = $urandom_range(1, 6);
    else if (r < 95) len = $urandom_range(7, 30);
    else len = $urandom_range(78, 85);
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_read();
      end else if (r < 13) begin
        send_request(tcw_pkg::REQ_PUT, tcw_pkg::CH_BACKSPACE,
                     ROW_IN_W'($urandom), COL_IN_W'($urandom));
      end else if (r < 15) begin
        send_request(REQ_IGNORED, CHAR_W'($urandom), ROW_IN_W'($urandom), COL_IN_W'($urandom));
      end else begin
        send_request(tcw_pkg::REQ_PUT, CHAR_W'($urandom),
                     ROW_IN_W'($urandom), COL_IN_W'($urandom));
      end
    end
    if ($urandom_range(0, 199) < 3)
      send_request(tcw_pkg::REQ_CLEAR, CHAR_W'($urandom),
                   ROW_IN_W'($urandom), COL_IN_W'($urandom));
    else
      send_request(tcw_pkg::REQ_PUT, tcw_pkg::CH_NEWLINE,
                   ROW_IN_W'($urandom), COL_IN_W'($urandom));
    if ($urandom_range(0, 3) == 0) send_read();
  endtask

  // Result side: random back-pressure, plus one long hold on request
  initial begin
    int gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (receiver_hold_request != 0) begin
        gap = receiver_hold_request;
        receiver_hold_request = 0;
      end else begin
        gap = pick_gap(receiver_idle);
      end
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      board.check_result(cursor_pos_o, cell_char_o, cell_attr_o);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[%0t] watchdog: no beat for %0d cycles, %0d results outstanding",
               $realtime, STALL_LIMIT, board.pending());
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [ATTR_W-1:0] phase_attr [5];
    int phase_end;

    board       = new();
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    req_type_i  = tcw_pkg::REQ_PUT;
    char_code_i = '0;
    cell_row_i  = '0;
    cell_col_i  = '0;
    sender_idle   = 1'b0;
    receiver_idle = 1'b1;
    receiver_hold_request = 0;
    n_items    = 0;
    n_ignored  = 0;
    n_settings = 0;
    quiet_cycles = 0;

    phase_attr[0] = 8'hFF;
    phase_attr[1] = ATTR_W'($urandom);
    phase_attr[2] = 8'h80;
    phase_attr[3] = ATTR_W'($urandom);
    phase_attr[4] = 8'h01;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset contents, out-of-grid reads, backspace at the left margin
    send_request(tcw_pkg::REQ_READ, 8'h00, 5'd0, 7'd0);
    send_request(tcw_pkg::REQ_READ, 8'h00, 5'(ROWS - 1), 7'(COLUMNS - 1));
    send_request(tcw_pkg::REQ_READ, 8'h00, 5'(ROWS), 7'd0);
    send_request(tcw_pkg::REQ_READ, 8'h00, 5'd0, 7'(COLUMNS));
    send_request(tcw_pkg::REQ_READ, 8'hFF, 5'(ROW_MAX), 7'(COL_MAX));
    send_request(tcw_pkg::REQ_PUT, tcw_pkg::CH_BACKSPACE, 5'd0, 7'd0);
    send_request(tcw_pkg::REQ_PUT, 8'h00, 5'd0, 7'd0);
    send_request(tcw_pkg::REQ_PUT, 8'hFF, 5'(ROW_MAX), 7'(COL_MAX));
    send_request(tcw_pkg::REQ_PUT, 8'h41, 5'd0, 7'd0);
    send_request(tcw_pkg::REQ_PUT, tcw_pkg::CH_BACKSPACE, 5'd0, 7'd0);
    send_request(tcw_pkg::REQ_READ, 8'h00, 5'd0, 7'd1);
    send_request(tcw_pkg::REQ_READ, 8'h00, 5'd0, 7'd2);
    send_request(tcw_pkg::REQ_PUT, tcw_pkg::CH_NEWLINE, 5'd0, 7'd0);
    send_request(REQ_IGNORED, 8'hFF, 5'(ROW_MAX), 7'(COL_MAX));
    send_request(tcw_pkg::REQ_READ, 8'h00, 5'd0, 7'd0);
    settle();

    // blanks and clear under attribute zero
    write_attribute(8'h00);
    send_request(tcw_pkg::REQ_PUT, 8'h7F, 5'd0, 7'd0);
    send_request(tcw_pkg::REQ_PUT, tcw_pkg::CH_BACKSPACE, 5'd0, 7'd0);
    send_request(tcw_pkg::REQ_READ, 8'h00, 5'd1, 7'd0);
    send_request(tcw_pkg::REQ_CLEAR, 8'h00, 5'd0, 7'd0);
    send_request(tcw_pkg::REQ_READ, 8'h00, 5'd0, 7'd0);
    send_request(tcw_pkg::REQ_READ, 8'h00, 5'(ROWS - 1), 7'(COLUMNS - 1));
    send_request(tcw_pkg::REQ_PUT, tcw_pkg::CH_NEWLINE, 5'd0, 7'd0);
    send_request(REQ_IGNORED, 8'h00, 5'd0, 7'd0);
    settle();

    for (int phase = 0; phase < 5; phase++) begin
      write_attribute(phase_attr[phase]);
      sender_idle   = (phase == 0 || phase == 3 || phase == 4);
      receiver_idle = (phase != 1 && phase != 3);
      // receiver stalls long while requests keep coming
      if (phase == 2) receiver_hold_request = PRESSURE_HOLD;
      phase_end = n_items + 56;
      while (n_items < phase_end) type_line();
      settle();
    end

    repeat (20) @(posedge clk_i);

    $display("Ran %0d requests and %0d ignored codes: %0d wraps, %0d scrolls, %0d clears",
             n_items, n_ignored, board.wraps, board.scrolls, board.clears);
    $display("Read %0d cells in the grid and %0d outside; %0d result beats checked, %0d attributes",
             board.reads_in, board.reads_out, board.checked, n_settings);
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
